/* hdl/fsbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types, codes and lookup tables for the fan speed button controller.
// ----------------------------------------------------------------------------
package fsbc_pkg;

    localparam logic [1:0] ACT_POLL = 2'd0;
    localparam logic [1:0] ACT_LEAVE_DONE = 2'd1;
    localparam logic [1:0] ACT_JOIN_DONE = 2'd2;

    localparam logic [1:0] JOIN_NONE = 2'd0;
    localparam logic [1:0] JOIN_START = 2'd1;
    localparam logic [1:0] JOIN_RETRY = 2'd2;

    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_PAIR_HOLD = 2'd1;
    localparam logic [1:0] CFG_RESET_HOLD = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0] MAX_STEP = 4'd10;

    localparam logic [9:0] POLL_INTERVAL_RST = 10'd50;
    localparam logic [15:0] PAIR_HOLD_RST = 16'd1000;
    localparam logic [15:0] RESET_HOLD_RST = 16'd10000;
    localparam logic [3:0] LAST_STEP_RST = 4'd10;

    typedef struct packed {
        logic [1:0] action;
        logic [31:0] now_ms;
        logic mode_pressed;
        logic toggle_pressed;
        logic up_pressed;
        logic down_pressed;
        logic status_ok;
    } item_t;

    typedef struct packed {
        logic [3:0] fan_step;
        logic [12:0] pwm_duty;
        logic [7:0] level_attr;
        logic onoff_attr;
        logic pairing_active;
        logic reset_pending;
        logic leave_request;
        logic [1:0] join_request;
        logic poll_taken;
    } result_t;

    typedef struct packed {
        logic [9:0] poll_interval_ms;
        logic [15:0] pair_hold_ms;
        logic [15:0] reset_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] last_poll_time;
        logic [31:0] hold_start_time;
        logic mode_held;
        logic [3:0] speed_step;
        logic [3:0] last_nonzero_step;
        logic [7:0] level_value;
        logic on_flag;
        logic leave_pending;
        logic pairing_flag;
    } state_t;

    function automatic logic [12:0] duty_lut(input logic [3:0] step);
        logic [12:0] duty;
        case (step)
            4'd0: duty = 13'd0;
            4'd1: duty = 13'd3112;
            4'd2: duty = 13'd3510;
            4'd3: duty = 13'd4095;
            4'd4: duty = 13'd4680;
            4'd5: duty = 13'd5265;
            4'd6: duty = 13'd5850;
            4'd7: duty = 13'd6435;
            4'd8: duty = 13'd7020;
            4'd9: duty = 13'd7605;
            default: duty = 13'd8191;
        endcase
        return duty;
    endfunction

    function automatic logic [7:0] level_lut(input logic [3:0] step);
        logic [7:0] level;
        case (step)
            4'd0: level = 8'd0;
            4'd1: level = 8'd26;
            4'd2: level = 8'd51;
            4'd3: level = 8'd77;
            4'd4: level = 8'd102;
            4'd5: level = 8'd128;
            4'd6: level = 8'd153;
            4'd7: level = 8'd179;
            4'd8: level = 8'd204;
            4'd9: level = 8'd230;
            default: level = 8'd255;
        endcase
        return level;
    endfunction

endpackage
`default_nettype wire

/* hdl/fsbc_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsbc_step
// Single-pass update of the controller state for one beat, with its result.
// ----------------------------------------------------------------------------
module fsbc_step (
    input  wire fsbc_pkg::cfg_t    cfg,
    input  wire fsbc_pkg::state_t  state,
    input  wire fsbc_pkg::item_t   item,
    output fsbc_pkg::state_t       state_next,
    output fsbc_pkg::result_t      result
);

    fsbc_pkg::state_t s;
    logic [31:0] since_poll;
    logic [31:0] held_for;
    logic leave_now;
    logic [1:0] join_req;
    logic taken;
    logic skip;

    assign since_poll = item.now_ms - state.last_poll_time;
    assign held_for = item.now_ms - state.hold_start_time;

    always_comb
    begin
        s = state;
        leave_now = 1'b0;
        join_req = fsbc_pkg::JOIN_NONE;
        taken = 1'b0;
        skip = 1'b0;
        unique case (item.action)
            fsbc_pkg::ACT_POLL:
            begin
                if (since_poll >= {22'd0, cfg.poll_interval_ms})
                begin
                    taken = 1'b1;
                    s.last_poll_time = item.now_ms;
                    if (item.mode_pressed)
                    begin
                        if (!state.mode_held)
                        begin
                            s.hold_start_time = item.now_ms;
                            s.mode_held = 1'b1;
                        end
                        else if (held_for >= {16'd0, cfg.reset_hold_ms})
                        begin
                            s.leave_pending = 1'b1;
                            leave_now = 1'b1;
                            s.mode_held = 1'b0;
                            skip = 1'b1;
                        end
                    end
                    else
                    begin
                        if (state.mode_held && held_for >= {16'd0, cfg.pair_hold_ms}
                            && held_for < {16'd0, cfg.reset_hold_ms})
                        begin
                            s.pairing_flag = 1'b1;
                            join_req = fsbc_pkg::JOIN_START;
                        end
                        s.mode_held = 1'b0;
                    end
                    if (!skip && !s.leave_pending)
                    begin
                        if (item.toggle_pressed)
                        begin
                            if (s.speed_step == 4'd0)
                            begin
                                s.on_flag = 1'b1;
                                s.speed_step = s.last_nonzero_step;
                            end
                            else
                            begin
                                s.on_flag = 1'b0;
                                s.speed_step = 4'd0;
                            end
                            s.level_value = fsbc_pkg::level_lut(s.speed_step);
                        end
                        if (item.up_pressed && s.speed_step < fsbc_pkg::MAX_STEP)
                        begin
                            s.speed_step = s.speed_step + 4'd1;
                            s.last_nonzero_step = s.speed_step;
                            s.on_flag = 1'b1;
                            s.level_value = fsbc_pkg::level_lut(s.speed_step);
                        end
                        if (item.down_pressed && s.speed_step != 4'd0)
                        begin
                            s.speed_step = s.speed_step - 4'd1;
                            if (s.speed_step != 4'd0)
                            begin
                                s.on_flag = 1'b1;
                                s.last_nonzero_step = s.speed_step;
                            end
                            else
                            begin
                                s.on_flag = 1'b0;
                            end
                            s.level_value = fsbc_pkg::level_lut(s.speed_step);
                        end
                    end
                end
            end
            fsbc_pkg::ACT_LEAVE_DONE:
            begin
                s.leave_pending = 1'b0;
                if (item.status_ok)
                begin
                    join_req = fsbc_pkg::JOIN_START;
                end
            end
            fsbc_pkg::ACT_JOIN_DONE:
            begin
                if (item.status_ok)
                begin
                    s.pairing_flag = 1'b0;
                end
                else if (state.pairing_flag)
                begin
                    join_req = fsbc_pkg::JOIN_RETRY;
                end
            end
            default:
            begin
                s = state;
            end
        endcase
    end

    assign state_next = s;

    assign result.fan_step = s.speed_step;
    assign result.pwm_duty = fsbc_pkg::duty_lut(s.speed_step);
    assign result.level_attr = s.level_value;
    assign result.onoff_attr = s.on_flag;
    assign result.pairing_active = s.pairing_flag;
    assign result.reset_pending = s.leave_pending;
    assign result.leave_request = leave_now;
    assign result.join_request = join_req;
    assign result.poll_taken = taken;

endmodule
`default_nettype wire

/* hdl/fan_speed_button_controller_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_button_controller_core
// Button poll and network event handling for a stepped fan with pwm duty.
// ----------------------------------------------------------------------------
// One beat is accepted every clock cycle while item_ready is high. An accepted
// beat is captured in the input register, the state update and result are
// computed from it in a single combinational pass, and the result is held in
// the output register, from which it is offered. The input register keeps
// taking beats while a result waits for result_ready; it stalls only when both
// registers are full and result_ready is low. Configuration writes take effect
// on the next edge and are expected only while no beat is in flight.
module fan_speed_button_controller_core (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   item_valid,
    output logic                                  item_ready,
    input  wire fsbc_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire                                   result_ready,
    output fsbc_pkg::result_t                     result,
    input  wire                                   cfg_write,
    input  wire [fsbc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [fsbc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    fsbc_pkg::cfg_t cfg_reg;
    fsbc_pkg::state_t state_reg;
    fsbc_pkg::state_t state_next;
    fsbc_pkg::item_t item_reg;
    fsbc_pkg::result_t result_reg;
    fsbc_pkg::result_t result_next;
    logic item_valid_reg;
    logic result_valid_reg;
    logic advance;

    assign advance = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval_ms <= fsbc_pkg::POLL_INTERVAL_RST;
            cfg_reg.pair_hold_ms <= fsbc_pkg::PAIR_HOLD_RST;
            cfg_reg.reset_hold_ms <= fsbc_pkg::RESET_HOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fsbc_pkg::CFG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= cfg_data[9:0];
                fsbc_pkg::CFG_PAIR_HOLD: cfg_reg.pair_hold_ms <= cfg_data;
                fsbc_pkg::CFG_RESET_HOLD: cfg_reg.reset_hold_ms <= cfg_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg.last_poll_time <= 32'd0;
            state_reg.hold_start_time <= 32'd0;
            state_reg.mode_held <= 1'b0;
            state_reg.speed_step <= 4'd0;
            state_reg.last_nonzero_step <= fsbc_pkg::LAST_STEP_RST;
            state_reg.level_value <= 8'd0;
            state_reg.on_flag <= 1'b0;
            state_reg.leave_pending <= 1'b0;
            state_reg.pairing_flag <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg <= state_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    fsbc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

`ifndef SYNTHESIS
    assert_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.speed_step <= fsbc_pkg::MAX_STEP
        && state_reg.last_nonzero_step != 4'd0)
        else $error("speed step out of range");

    assert_onoff_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.onoff_attr == (result_reg.fan_step != 4'd0)))
        else $error("on/off attribute disagrees with fan speed");

    assert_leave_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.leave_request |-> result_reg.reset_pending
        && result_reg.poll_taken)
        else $error("leave request without pending leave");

    assert_retry_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.join_request == fsbc_pkg::JOIN_RETRY
        |-> !result_reg.poll_taken && result_reg.pairing_active)
        else $error("join retry from a poll beat");

    assert_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled beat lost from input register");
`endif

endmodule
`default_nettype wire
